// ===== rtl/core/hts_pkg.sv =====
// Shared types and constants of the heightmap triangle height sampler.
`default_nettype none

package hts_pkg;

    localparam int MAP_DIM     = 256;
    localparam int COORD_W     = $clog2(MAP_DIM);
    localparam int HALF_W      = COORD_W - 1;
    localparam int BANK_AW     = 2 * HALF_W;
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int FRAC_BITS   = 8;
    localparam int SCALE_FRAC  = 8;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 18;
    localparam int DIM_W       = 9;
    localparam int SCALE_W     = 16;
    localparam int HEIGHT_W    = 26;
    localparam int CORNER_W    = PIX_W + 3;
    localparam int TERM_W      = CORNER_W + FRAC_BITS + 2;
    localparam int SUM_W       = TERM_W + FRAC_BITS + 2;
    localparam int HPOS_W      = PIX_W + 1 + 2 * FRAC_BITS;
    localparam int PROD_W      = HPOS_W + SCALE_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [DIM_W-1:0]   DIM_MAX     = DIM_W'(MAP_DIM);
    localparam logic [DIM_W-1:0]   WIDTH_RST   = DIM_W'(256);
    localparam logic [DIM_W-1:0]   LENGTH_RST  = DIM_W'(256);
    localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(256);
    localparam logic [FRAC_BITS:0] FRAC_ONE    = (FRAC_BITS + 1)'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        REG_MAP_WIDTH    = 2'd0,
        REG_MAP_LENGTH   = 2'd1,
        REG_HEIGHT_SCALE = 2'd2
    } t_reg_idx;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                         is_query;
        logic                         outside;
        logic                         zp0;
        logic                         zp1;
        logic                         xp0;
        logic                         xp1;
        logic [1:0][HALF_W-1:0]       row_hi;
        logic [1:0][HALF_W-1:0]       col_hi;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fz;
        logic [PIX_W-1:0]             pixel;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/core/hts_front.sv =====
// Front end: accepts input beats, classifies loads and queries, computes corner addresses.
`default_nettype none

module hts_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_mode,
    input  wire logic [hts_pkg::COORD_W-1:0]   i_load_column,
    input  wire logic [hts_pkg::COORD_W-1:0]   i_load_row,
    input  wire logic [hts_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic signed [hts_pkg::POS_W-1:0] i_sample_x,
    input  wire logic signed [hts_pkg::POS_W-1:0] i_sample_z,
    input  wire logic [hts_pkg::DIM_W-1:0]     i_map_width,
    input  wire logic [hts_pkg::DIM_W-1:0]     i_map_length,
    output logic                               o_push,
    output hts_pkg::t_item                     o_item,
    input  wire logic                          i_full
);
    import hts_pkg::*;

    logic                   r_fv;
    logic                   n_fv;
    t_item                  r_item;
    t_item                  n_item;
    logic                   accept;
    logic                   useful;
    logic [DIM_W-1:0]       w_eff;
    logic [DIM_W-1:0]       l_eff;
    logic [DIM_W-1:0]       frow;
    logic [COORD_W-1:0]     xi;
    logic [COORD_W-1:0]     zi;
    logic [COORD_W-1:0]     x1;
    logic [COORD_W-1:0]     z1;
    logic [DIM_W-1:0]       x1_sum;
    logic [DIM_W-1:0]       z1_sum;
    logic                   x_out;
    logic                   z_out;
    logic                   load_ok;

    assign w_eff = (i_map_width > DIM_MAX) ? DIM_MAX : i_map_width;
    assign l_eff = (i_map_length > DIM_MAX) ? DIM_MAX : i_map_length;

    assign o_stall = r_fv && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_fv && !i_full;
    assign o_item  = r_item;

    always_comb begin
        x_out  = i_sample_x[POS_W-1] ||
                 (i_sample_x[POS_W-2:0] >= {w_eff, {FRAC_BITS{1'b0}}});
        z_out  = i_sample_z[POS_W-1] ||
                 (i_sample_z[POS_W-2:0] >= {l_eff, {FRAC_BITS{1'b0}}});
        xi     = i_sample_x[FRAC_BITS +: COORD_W];
        zi     = i_sample_z[FRAC_BITS +: COORD_W];
        x1_sum = {1'b0, xi} + DIM_W'(1);
        z1_sum = {1'b0, zi} + DIM_W'(1);
        // Past the last column or row the neighbor is the sample itself.
        x1     = (x1_sum < w_eff) ? x1_sum[COORD_W-1:0] : xi;
        z1     = (z1_sum < l_eff) ? z1_sum[COORD_W-1:0] : zi;
        frow   = l_eff - DIM_W'(1) - {1'b0, i_load_row};
        load_ok = ({1'b0, i_load_column} < w_eff) && ({1'b0, i_load_row} < l_eff);

        n_item          = r_item;
        n_item.is_query = i_mode;
        n_item.pixel    = i_pixel;
        n_item.fx       = i_sample_x[FRAC_BITS-1:0];
        n_item.fz       = i_sample_z[FRAC_BITS-1:0];
        if (i_mode) begin
            n_item.outside   = x_out || z_out;
            n_item.xp0       = xi[0];
            n_item.xp1       = x1[0];
            n_item.zp0       = zi[0];
            n_item.zp1       = z1[0];
            n_item.col_hi[0] = xi[0] ? x1[COORD_W-1:1] : xi[COORD_W-1:1];
            n_item.col_hi[1] = xi[0] ? xi[COORD_W-1:1] : x1[COORD_W-1:1];
            n_item.row_hi[0] = zi[0] ? z1[COORD_W-1:1] : zi[COORD_W-1:1];
            n_item.row_hi[1] = zi[0] ? zi[COORD_W-1:1] : z1[COORD_W-1:1];
            useful           = 1'b1;
        end else begin
            n_item.outside   = 1'b0;
            n_item.xp0       = i_load_column[0];
            n_item.xp1       = i_load_column[0];
            n_item.zp0       = frow[0];
            n_item.zp1       = frow[0];
            n_item.col_hi[0] = i_load_column[COORD_W-1:1];
            n_item.col_hi[1] = i_load_column[COORD_W-1:1];
            n_item.row_hi[0] = frow[COORD_W-1:1];
            n_item.row_hi[1] = frow[COORD_W-1:1];
            useful           = load_ok;
        end

        n_fv = r_fv;
        if (accept) begin
            n_fv = useful;
        end else if (o_push) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_fv)
        else $error("front stalls with no item held");

endmodule

`default_nettype wire

// ===== rtl/core/hts_queue.sv =====
// Short queue of classified items between front and back.
`default_nettype none

module hts_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  hts_pkg::t_item      i_item,
    output logic                o_full,
    output logic                o_empty,
    input  wire logic           i_pop,
    output hts_pkg::t_item      o_head
);
    import hts_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_AW:0]      r_count;
    logic [Q_AW:0]      n_count;

    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (Q_AW + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== rtl/core/hts_back.sv =====
// Back end: banked height store, triangle-split bilinear filter, scaling, output register.
`default_nettype none

module hts_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_empty,
    input  hts_pkg::t_item                       i_head,
    output logic                                 o_pop,
    input  wire logic [hts_pkg::SCALE_W-1:0]     i_height_scale,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [hts_pkg::HEIGHT_W-1:0]  o_height,
    output logic                                 o_outside_map
);
    import hts_pkg::*;

    logic                         adv;
    logic                         wr_en;
    logic [1:0]                   wr_bank;
    logic [BANK_AW-1:0]           wr_addr;
    logic [PIX_W-1:0]             w_rd [4];
    logic [3:0][PIX_W-1:0]        rd_all;

    // stage 1: store read
    logic                         r_s1_valid;
    logic                         r_s1_out;
    logic                         r_s1_zp0, r_s1_zp1, r_s1_xp0, r_s1_xp1;
    logic [FRAC_BITS-1:0]         r_s1_fx, r_s1_fz;
    // stage 2: corners after the diagonal split
    logic                         r_s2_valid;
    logic                         r_s2_out;
    logic [FRAC_BITS-1:0]         r_s2_fx, r_s2_fz;
    logic signed [CORNER_W-1:0]   r_tl, r_tr, r_bl, r_br;
    logic signed [CORNER_W-1:0]   n_tl, n_tr, n_bl, n_br;
    // stage 3: horizontal blend
    logic                         r_s3_valid;
    logic                         r_s3_out;
    logic [FRAC_BITS-1:0]         r_s3_fz;
    logic signed [TERM_W-1:0]     r_top, r_bot;
    logic signed [TERM_W-1:0]     n_top, n_bot;
    // stage 4: vertical blend, clamped at zero
    logic                         r_s4_valid;
    logic                         r_s4_out;
    logic [HPOS_W-1:0]            r_h;
    logic signed [SUM_W-1:0]      n_sum;
    // output register
    logic                         r_ov;
    logic                         r_oout;
    logic [HEIGHT_W-1:0]          r_oh;
    logic [PROD_W-1:0]            n_prod;

    logic [FRAC_BITS:0]           s2_omfx;
    logic [FRAC_BITS:0]           s3_omfx;
    logic [FRAC_BITS:0]           s3_omfz;

    assign adv   = !r_ov || !i_stall;
    assign o_pop = adv && !i_empty;
    assign wr_en = o_pop && !i_head.is_query;
    assign wr_bank = {i_head.zp0, i_head.xp0};
    assign wr_addr = {i_head.row_hi[i_head.zp0], i_head.col_hi[i_head.xp0]};

    // Four banks by row and column parity, so every corner of a cell is in its own bank.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam int RP = b / 2;
        localparam int CP = b % 2;
        logic [PIX_W-1:0]   mem [BANK_DEPTH];
        logic [PIX_W-1:0]   r_q;
        logic [BANK_AW-1:0] rd_addr;

        assign rd_addr = {i_head.row_hi[RP], i_head.col_hi[CP]};
        assign w_rd[b] = r_q;

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                mem[wr_addr] <= i_head.pixel;
            end
            if (adv) begin
                r_q <= mem[rd_addr];
            end
        end
    end

    assign rd_all = {w_rd[3], w_rd[2], w_rd[1], w_rd[0]};

    always_comb begin
        n_bl = $signed({3'b000, rd_all[{r_s1_zp0, r_s1_xp0}]});
        n_br = $signed({3'b000, rd_all[{r_s1_zp0, r_s1_xp1}]});
        n_tl = $signed({3'b000, rd_all[{r_s1_zp1, r_s1_xp0}]});
        n_tr = $signed({3'b000, rd_all[{r_s1_zp1, r_s1_xp1}]});
        s2_omfx = FRAC_ONE - {1'b0, r_s1_fx};
        if (r_s1_zp0) begin
            if (r_s1_fz >= r_s1_fx) begin
                n_br = n_bl - (n_tr - n_tl);
            end else begin
                n_tl = n_tr + (n_bl - n_br);
            end
        end else begin
            if ({1'b0, r_s1_fz} < s2_omfx) begin
                n_tr = n_tl + (n_br - n_bl);
            end else begin
                n_bl = n_tl + (n_br - n_tr);
            end
        end
    end

    always_comb begin
        s3_omfx = FRAC_ONE - {1'b0, r_s2_fx};
        n_top = r_tl * $signed({1'b0, s3_omfx}) + r_tr * $signed({2'b00, r_s2_fx});
        n_bot = r_bl * $signed({1'b0, s3_omfx}) + r_br * $signed({2'b00, r_s2_fx});
    end

    always_comb begin
        s3_omfz = FRAC_ONE - {1'b0, r_s3_fz};
        n_sum = r_bot * $signed({1'b0, s3_omfz}) + r_top * $signed({2'b00, r_s3_fz});
    end

    // The blended value stays below 2^25, so the scaled result never reaches saturation.
    assign n_prod = r_h * i_height_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= o_pop && i_head.is_query;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_ov       <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_out <= i_head.outside;
            r_s1_zp0 <= i_head.zp0;
            r_s1_zp1 <= i_head.zp1;
            r_s1_xp0 <= i_head.xp0;
            r_s1_xp1 <= i_head.xp1;
            r_s1_fx  <= i_head.fx;
            r_s1_fz  <= i_head.fz;

            r_s2_out <= r_s1_out;
            r_s2_fx  <= r_s1_fx;
            r_s2_fz  <= r_s1_fz;
            r_tl     <= n_tl;
            r_tr     <= n_tr;
            r_bl     <= n_bl;
            r_br     <= n_br;

            r_s3_out <= r_s2_out;
            r_s3_fz  <= r_s2_fz;
            r_top    <= n_top;
            r_bot    <= n_bot;

            r_s4_out <= r_s3_out;
            r_h      <= n_sum[SUM_W-1] ? '0 : n_sum[HPOS_W-1:0];

            r_oout   <= r_s4_out;
            r_oh     <= r_s4_out ? '0
                        : {1'b0, n_prod[PROD_W-1 -: HEIGHT_W-1]};
        end
    end

    assign o_valid       = r_ov;
    assign o_height      = $signed(r_oh);
    assign o_outside_map = r_oout;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outside_map |-> o_height == '0)
        else $error("outside query with nonzero height");

    a_height_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_height[HEIGHT_W-1])
        else $error("negative height delivered");

endmodule

`default_nettype wire

// ===== rtl/core/heightmap_triangle_height_sampler.sv =====
// Top level of the heightmap triangle height sampler: register file and front/queue/back.
`default_nettype none

// Accepts one beat per clock while o_stall is low, loads and queries mixed in any order; each
// query gives one result beat, a load gives none. A query passes the front register, the
// 4-entry queue, the pop that latches the store read, and then the back pipeline (diagonal
// split, horizontal blend, vertical blend, scale multiply into the output register). The
// height store is four banks of 16384 bytes split by row and column parity; each bank has
// one read and one write port, so the four corners of a cell are read in the same cycle and
// a load written in the cycle before a query's store read is already visible to it. The
// store is not cleared at reset: a query must only touch samples that were loaded.
// Registers (map_width at 0x0, map_length at 0x4, height_scale at 0x8) must be written
// only while the block is idle; the block itself does not enforce this.
module heightmap_triangle_height_sampler (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [hts_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [hts_pkg::PDATA_W-1:0]          pwdata,
    output logic [hts_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_mode,
    input  wire logic [7:0]                           i_load_column,
    input  wire logic [7:0]                           i_load_row,
    input  wire logic [7:0]                           i_pixel,
    input  wire logic signed [hts_pkg::POS_W-1:0]     i_sample_x,
    input  wire logic signed [hts_pkg::POS_W-1:0]     i_sample_z,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [hts_pkg::HEIGHT_W-1:0]       o_height,
    output logic                                      o_outside_map
);
    import hts_pkg::*;

    logic [DIM_W-1:0]   r_map_width;
    logic [DIM_W-1:0]   r_map_length;
    logic [SCALE_W-1:0] r_height_scale;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic               push;
    logic               full;
    logic               empty;
    logic               pop;
    t_item              front_item;
    t_item              head_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= WIDTH_RST;
            r_map_length   <= LENGTH_RST;
            r_height_scale <= SCALE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MAP_WIDTH:    r_map_width    <= pwdata[DIM_W-1:0];
                REG_MAP_LENGTH:   r_map_length   <= pwdata[DIM_W-1:0];
                REG_HEIGHT_SCALE: r_height_scale <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAP_WIDTH:    prdata = {{(PDATA_W - DIM_W){1'b0}}, r_map_width};
            REG_MAP_LENGTH:   prdata = {{(PDATA_W - DIM_W){1'b0}}, r_map_length};
            REG_HEIGHT_SCALE: prdata = {{(PDATA_W - SCALE_W){1'b0}}, r_height_scale};
            default:          prdata = '0;
        endcase
    end

    hts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_load_column (i_load_column),
        .i_load_row    (i_load_row),
        .i_pixel       (i_pixel),
        .i_sample_x    (i_sample_x),
        .i_sample_z    (i_sample_z),
        .i_map_width   (r_map_width),
        .i_map_length  (r_map_length),
        .o_push        (push),
        .o_item        (front_item),
        .i_full        (full)
    );

    hts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (head_item)
    );

    hts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head_item),
        .o_pop          (pop),
        .i_height_scale (r_height_scale),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_height       (o_height),
        .o_outside_map  (o_outside_map)
    );

endmodule

`default_nettype wire
